@@ design/wtsc_pkg.sv @@
// Shared types and constants for the wave-table sound channel.
// No dependencies; imported by the wave RAM, the core and the top level.
package wtsc_pkg;

	localparam int RAM_BYTES = 16;
	localparam int RAM_IDX_W = $clog2(RAM_BYTES);

	typedef enum logic [2:0] {
		CMD_CLOCKS    = 3'd0,
		CMD_REG_WR    = 3'd1,
		CMD_REG_RD    = 3'd2,
		CMD_RAM_WR    = 3'd3,
		CMD_RAM_RD    = 3'd4,
		CMD_LEN_CLK   = 3'd5,
		CMD_POWER_OFF = 3'd6,
		CMD_LEN_RST   = 3'd7
	} cmd_t;

	// register indexes
	localparam logic [3:0] REG_DAC = 4'd0;
	localparam logic [3:0] REG_LEN = 4'd1;
	localparam logic [3:0] REG_VOL = 4'd2;
	localparam logic [3:0] REG_FLO = 4'd3;
	localparam logic [3:0] REG_FHI = 4'd4;

	// open-bus read masks
	localparam logic [7:0] OPEN_DAC  = 8'h7F;
	localparam logic [7:0] OPEN_VOL  = 8'h9F;
	localparam logic [7:0] OPEN_FHI  = 8'hBF;
	localparam logic [7:0] OPEN_FULL = 8'hFF;

	localparam logic [12:0] PERIOD_RESET = 13'd4096;
	localparam logic [8:0]  LEN_FULL     = 9'd256;

	localparam logic [7:0] RAM_PRESET [RAM_BYTES] = '{
		8'h84, 8'h40, 8'h43, 8'hAA, 8'h2D, 8'h78, 8'h92, 8'h3C,
		8'h60, 8'h59, 8'h59, 8'hB0, 8'h34, 8'hB8, 8'h2E, 8'hDA
	};

	typedef struct packed {
		cmd_t        cmd;
		logic [3:0]  addr;
		logic [7:0]  wdata;
		logic [3:0]  clocks;
	} item_t;

	typedef struct packed {
		logic [7:0] rdata;
		logic [3:0] sample_out;
		logic       channel_on;
	} result_t;

	// wave RAM control from the channel core
	typedef struct packed {
		logic                 wr_en;
		logic [RAM_IDX_W-1:0] wr_idx;
		logic [7:0]           wr_data;
		logic                 corrupt;
	} ram_ctl_t;

endpackage

@@ design/wtsc_wave_ram.sv @@
// Wave RAM: 16 bytes in flops, preset at reset, two read ports and the
// trigger corruption copy. Depends on wtsc_pkg.
module wtsc_wave_ram (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wtsc_pkg::ram_ctl_t            ctl,
	input  logic [wtsc_pkg::RAM_IDX_W-1:0] acc_idx,
	input  logic [wtsc_pkg::RAM_IDX_W-1:0] fetch_idx,
	output logic [7:0]                    acc_byte,
	output logic [7:0]                    fetch_byte
);
	import wtsc_pkg::*;

	logic [7:0] ram_q [RAM_BYTES];

	assign acc_byte   = ram_q[acc_idx];
	assign fetch_byte = ram_q[fetch_idx];

	// fetch_idx doubles as the corruption source row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RAM_BYTES; i++) ram_q[i] <= RAM_PRESET[i];
		end else if (ctl.wr_en) begin
			ram_q[ctl.wr_idx] <= ctl.wr_data;
		end else if (ctl.corrupt) begin
			if (fetch_idx < RAM_IDX_W'(4)) begin
				ram_q[0] <= fetch_byte;
			end else begin
				for (int k = 0; k < 4; k++)
					ram_q[k] <= ram_q[{fetch_idx[RAM_IDX_W-1:2], 2'(k)}];
			end
		end
	end

endmodule

@@ design/wtsc_core.sv @@
// Channel core: state registers and the combinational next-state/result logic.
// Depends on wtsc_pkg and wtsc_wave_ram.
module wtsc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  wtsc_pkg::item_t   item,
	input  logic              color_model,
	output wtsc_pkg::result_t res
);
	import wtsc_pkg::*;

	logic        dac_on_q, playing_q, length_on_q, ram_window_q;
	logic [3:0]  sample_hold_q, out_nibble_q;
	logic [4:0]  wave_pos_q;
	logic [1:0]  shift_sel_q;
	logic [10:0] period_code_q;
	logic [8:0]  length_left_q;
	logic [12:0] period_count_q;

	logic        dac_on_n, playing_n, length_on_n, ram_window_n;
	logic [3:0]  sample_hold_n, out_nibble_n;
	logic [4:0]  wave_pos_n;
	logic [1:0]  shift_sel_n;
	logic [10:0] period_code_n;
	logic [8:0]  length_left_n;
	logic [12:0] period_count_n;
	logic [7:0]  rdata_n;

	ram_ctl_t    ram_ctl;
	logic [4:0]  npos;
	logic [3:0]  acc_idx;
	logic [7:0]  acc_byte, fetch_byte;
	logic [3:0]  fetch_nib;
	logic        ram_ok;

	function automatic logic [3:0] shape(input logic [3:0] s, input logic [1:0] sh);
		logic [3:0] r;
		case (sh)
			2'd0:    r = 4'd0;
			2'd1:    r = s;
			2'd2:    r = s >> 1;
			default: r = s >> 2;
		endcase
		return r;
	endfunction

	function automatic logic [12:0] reload(input logic [10:0] code);
		logic [11:0] d;
		d = 12'd2048 - {1'b0, code};
		return {d, 1'b0};
	endfunction

	wtsc_wave_ram u_ram (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ram_ctl),
		.acc_idx    (acc_idx),
		.fetch_idx  (npos[4:1]),
		.acc_byte   (acc_byte),
		.fetch_byte (fetch_byte)
	);

	assign npos      = wave_pos_q + 5'd1;
	assign fetch_nib = npos[0] ? fetch_byte[3:0] : fetch_byte[7:4];
	assign acc_idx   = playing_q ? wave_pos_q[4:1] : item.addr;
	assign ram_ok    = !playing_q || ram_window_q || color_model;

	always_comb begin
		dac_on_n       = dac_on_q;
		playing_n      = playing_q;
		length_on_n    = length_on_q;
		ram_window_n   = ram_window_q;
		sample_hold_n  = sample_hold_q;
		out_nibble_n   = out_nibble_q;
		wave_pos_n     = wave_pos_q;
		shift_sel_n    = shift_sel_q;
		period_code_n  = period_code_q;
		length_left_n  = length_left_q;
		period_count_n = period_count_q;
		rdata_n        = 8'd0;
		ram_ctl        = '0;

		case (item.cmd)
			CMD_CLOCKS: begin
				if (playing_q) begin
					if ({9'd0, item.clocks} >= period_count_q) begin
						period_count_n = reload(period_code_q);
						wave_pos_n     = npos;
						sample_hold_n  = fetch_nib;
						out_nibble_n   = shape(fetch_nib, shift_sel_q);
						ram_window_n   = 1'b1;
					end else begin
						period_count_n = period_count_q - {9'd0, item.clocks};
						ram_window_n   = 1'b0;
					end
				end
			end
			CMD_REG_WR: begin
				case (item.addr)
					REG_DAC: begin
						dac_on_n  = item.wdata[7];
						playing_n = playing_q & item.wdata[7];
					end
					REG_LEN: length_left_n = LEN_FULL - {1'b0, item.wdata};
					REG_VOL: begin
						shift_sel_n  = item.wdata[6:5];
						out_nibble_n = shape(sample_hold_q, item.wdata[6:5]);
					end
					REG_FLO: period_code_n = {period_code_q[10:8], item.wdata};
					REG_FHI: begin
						period_code_n = {item.wdata[2:0], period_code_q[7:0]};
						if (item.wdata[7]) begin
							// trigger during a fetch on the monochrome model
							ram_ctl.corrupt = fire && playing_q
								&& (period_count_q <= 13'd2) && !color_model;
							playing_n = dac_on_q;
							if (dac_on_q) out_nibble_n = shape(sample_hold_q, shift_sel_q);
							period_count_n = reload(period_code_n) + 13'd6;
							if (length_left_q == 9'd0) length_left_n = LEN_FULL;
							wave_pos_n = 5'd0;
						end
						length_on_n = item.wdata[6];
					end
					default: ;
				endcase
			end
			CMD_REG_RD: begin
				case (item.addr)
					REG_DAC: rdata_n = OPEN_DAC | {dac_on_q, 7'd0};
					REG_VOL: rdata_n = OPEN_VOL | {1'b0, shift_sel_q, 5'd0};
					REG_FHI: rdata_n = OPEN_FHI | {1'b0, length_on_q, 6'd0};
					default: rdata_n = OPEN_FULL;
				endcase
			end
			CMD_RAM_WR: begin
				// RAM writes only on a processed item
				ram_ctl.wr_en   = fire && ram_ok;
				ram_ctl.wr_idx  = acc_idx;
				ram_ctl.wr_data = item.wdata;
			end
			CMD_RAM_RD: rdata_n = ram_ok ? acc_byte : OPEN_FULL;
			CMD_LEN_CLK: begin
				if (length_on_q && length_left_q != 9'd0) begin
					length_left_n = length_left_q - 9'd1;
					if (length_left_q == 9'd1) begin
						playing_n    = 1'b0;
						out_nibble_n = 4'd0;
					end
				end
			end
			CMD_POWER_OFF: begin
				dac_on_n       = 1'b0;
				playing_n      = 1'b0;
				sample_hold_n  = 4'd0;
				wave_pos_n     = 5'd0;
				shift_sel_n    = 2'd0;
				period_code_n  = 11'd0;
				length_on_n    = 1'b0;
				out_nibble_n   = 4'd0;
				period_count_n = PERIOD_RESET;
			end
			CMD_LEN_RST: length_left_n = 9'd0;
			default: ;
		endcase

		res.rdata      = rdata_n;
		res.sample_out = playing_n ? out_nibble_n : 4'd0;
		res.channel_on = playing_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dac_on_q       <= 1'b0;
			playing_q      <= 1'b0;
			length_on_q    <= 1'b0;
			ram_window_q   <= 1'b0;
			sample_hold_q  <= 4'd0;
			out_nibble_q   <= 4'd0;
			wave_pos_q     <= 5'd0;
			shift_sel_q    <= 2'd0;
			period_code_q  <= 11'd0;
			length_left_q  <= 9'd0;
			period_count_q <= PERIOD_RESET;
		end else if (fire) begin
			dac_on_q       <= dac_on_n;
			playing_q      <= playing_n;
			length_on_q    <= length_on_n;
			ram_window_q   <= ram_window_n;
			sample_hold_q  <= sample_hold_n;
			out_nibble_q   <= out_nibble_n;
			wave_pos_q     <= wave_pos_n;
			shift_sel_q    <= shift_sel_n;
			period_code_q  <= period_code_n;
			length_left_q  <= length_left_n;
			period_count_q <= period_count_n;
		end
	end

endmodule

@@ design/wave_table_sound_channel.sv @@
// Top level of the wave-table sound channel: input register, core, result
// register and stream handshake. Depends on wtsc_pkg and wtsc_core.
//
//  channel | dir | tdata (low bit up)                       | tuser
//  s_*     | in  | addr[3:0] wdata[11:4] clocks[15:12]      | cmd[2:0]
//  m_*     | out | rdata[7:0] sample_out[11:8] channel_on[12]| -
//  cfg_*   | in  | cfg_wdata = color_model, written on cfg_we | -
//
// One item per clock sustained while m_tready stays high. An accepted item waits in the input
// register while the core works it; its result is clocked into the result
// register once that register is free or being read, and shows from there.
// arst_n clears all control state and presets the wave RAM.
// A stalled result holds the result register; one more item may wait in the
// input register, after which s_tready drops until m_tready returns.
module wave_table_sound_channel (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // addr, wdata, clocks
	input  logic [2:0]  s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // rdata, sample_out, channel_on, zero pad
	input  logic        cfg_we,
	input  logic        cfg_wdata
);
	import wtsc_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    color_q;
	logic    adv;
	result_t res, res_q;
	logic    m_valid_q;

	// the core works on the held item when the result register can take it
	assign adv      = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.cmd    <= cmd_t'(s_tuser);
			item_s1.addr   <= s_tdata[3:0];
			item_s1.wdata  <= s_tdata[11:4];
			item_s1.clocks <= s_tdata[15:12];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= 1'b0;
		end else if (cfg_we) begin
			color_q <= cfg_wdata;
		end
	end

	wtsc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (adv),
		.item        (item_s1),
		.color_model (color_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) res_q <= res;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'd0, res_q.channel_on, res_q.sample_out, res_q.rdata};

endmodule

@@ design/wtsc_checker.sv @@
// Port-level checks for the wave-table sound channel, bound to the top.
// Depends on wave_table_sound_channel's port list only.
module wtsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// a silent channel never drives a nonzero sample
	a_off_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[12]) |-> (m_tdata[11:8] == 4'd0))
		else $error("sample nonzero while channel off");

	// input side only backs up behind a stalled result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("s_tready low without output stall");

	// an item taken behind a stalled result fills the only spare slot
	a_one_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && m_tvalid && !m_tready) |=> (m_tready || !s_tready))
		else $error("more than one item buffered behind a stall");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("result dropped while stalled");

endmodule

bind wave_table_sound_channel wtsc_checker u_wtsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
